[hw/rtl/multi_list_stack_queue_engine_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the list engine
// Short forms for concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_LIST_STACK_QUEUE_ENGINE_CORE_MACROS_SVH
`define MULTI_LIST_STACK_QUEUE_ENGINE_CORE_MACROS_SVH

// condition holds at every edge
`define MSQE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define MSQE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the trigger
`define MSQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/msqe_pkg.sv]
// ----------------------------------------------------------------------------
// msqe_pkg
// Command and status codes, field widths and controller states of the
// linked-list stack and queue engine.
// ----------------------------------------------------------------------------
package msqe_pkg;

  localparam int NUM_LISTS   = 16;
  localparam int LIST_ID_W   = 4;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_LINK = 5'b00100,
    S_POP  = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

endpackage

[hw/rtl/multi_list_stack_queue_engine_core.sv]
// ----------------------------------------------------------------------------
// multi_list_stack_queue_engine_core
// Sixteen numbered stacks or queues sharing one pool of linked entries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group, one create, push or pop per request,
//   and each request returns exactly one result on the m_axis group.
//   The engine works on one request at a time. s_axis_tready is high only
//   while it is idle, so it takes no new request before the last is done:
//   a create, a stack push or a rejected command passes S_LOOK and S_RESP;
//   a queue push onto a non-empty queue adds S_LINK and a successful pop
//   adds S_POP between the two. The extra state is set by the read latency
//   of the list table and the pool link memory: a pop reads the list, then
//   reads the head entry.
//   Results sit in an output register; the engine goes back to idle as soon
//   as that register has space, so under a stalled receiver one result waits
//   there while the next request is taken and finished behind it.
//   Reset (rst, synchronous) empties the output register, marks every list
//   absent and gives the whole pool back as free. No clearing pass runs:
//   pool entries never handed out are tracked by a high-water count, so
//   the engine is idle and can take a request as soon as reset ends.
// ----------------------------------------------------------------------------
`include "multi_list_stack_queue_engine_core_macros.svh"

module multi_list_stack_queue_engine_core #(
  parameter int POOL_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // command[1:0], list_id[5:2], list_kind[6], push_value[38:7], zero[39]
  input  logic [msqe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[2:0], value_valid[3], popped_value[35:4], zero[39:36]
  output logic [msqe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import msqe_pkg::*;

  localparam int PTR_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_ENTRIES);

  typedef struct packed {
    logic             is_queue;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [CNT_W-1:0] count;
  } list_entry_t;

  // Memories
  list_entry_t      list_mem [NUM_LISTS];
  logic [PTR_W-1:0] next_mem [POOL_ENTRIES];
  logic [DATA_W-1:0] data_mem [POOL_ENTRIES];

  // Memory ports
  logic              list_re, list_we;
  list_entry_t       list_wdata, list_q;
  logic              next_re, next_we;
  logic [PTR_W-1:0]  next_raddr, next_waddr, next_wdata, next_q;
  logic              data_re, data_we;
  logic [DATA_W-1:0] data_q;

  // Control state
  state_t                state, state_next;
  logic [NUM_LISTS-1:0]  exists;
  logic [PTR_W-1:0]      free_head;
  logic [CNT_W-1:0]      free_count;
  logic [CNT_W-1:0]      hwm;
  logic                  out_valid;

  // Request and result registers
  cmd_t                  req_cmd;
  logic [LIST_ID_W-1:0]  req_id;
  logic                  req_kind;
  logic [DATA_W-1:0]     req_value;
  logic [PTR_W-1:0]      alloc_ptr;
  status_t               res_status;
  logic                  res_valid;
  logic [DATA_W-1:0]     res_value;
  status_t               out_status;
  logic                  out_value_valid;
  logic [DATA_W-1:0]     out_value;

  // Decode signals
  logic              accept, out_free;
  logic              list_here, create_ok, push_ok, pop_ok, need_link;
  logic              virgin;
  logic [CNT_W-1:0]  hwm_inc;
  logic [PTR_W-1:0]  virgin_next, free_next_ptr;
  status_t           look_status;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_value, out_value_valid, out_status};

  // Free-list successor: untouched entries chain upward, others are linked
  assign hwm_inc       = hwm + CNT_W'(1);
  assign virgin        = (hwm < POOL_CNT) && (free_head == hwm[PTR_W-1:0]);
  assign virgin_next   = (hwm_inc == POOL_CNT) ? '0 : hwm_inc[PTR_W-1:0];
  assign free_next_ptr = virgin ? virgin_next : next_q;

  // Classify the request once the list entry is back
  always_comb begin
    list_here   = exists[req_id];
    create_ok   = 1'b0;
    push_ok     = 1'b0;
    pop_ok      = 1'b0;
    look_status = ST_OK;
    case (req_cmd)
      CMD_CREATE: begin
        if (list_here) look_status = ST_EXISTS;
        else create_ok = 1'b1;
      end
      CMD_PUSH: begin
        if (!list_here) look_status = ST_NOT_FOUND;
        else if (free_count == '0) look_status = ST_FULL;
        else push_ok = 1'b1;
      end
      CMD_POP: begin
        if (!list_here) look_status = ST_NOT_FOUND;
        else if (list_q.count == '0) look_status = ST_EMPTY;
        else pop_ok = 1'b1;
      end
      default: look_status = ST_OK;
    endcase
    need_link = push_ok && list_q.is_queue && (list_q.count != '0);
  end

  // Drive memory ports per state
  always_comb begin
    list_re    = accept;
    list_we    = 1'b0;
    list_wdata = list_q;
    next_re    = accept;
    next_raddr = accept ? free_head : list_q.head;
    next_we    = 1'b0;
    next_waddr = free_head;
    next_wdata = '0;
    data_re    = 1'b0;
    data_we    = 1'b0;
    if (state == S_LOOK) begin
      if (create_ok) begin
        list_we    = 1'b1;
        list_wdata = '{is_queue: req_kind, head: '0, tail: '0, count: '0};
      end
      if (push_ok) begin
        data_we    = 1'b1;
        next_we    = 1'b1;
        next_wdata = (list_q.count == '0 || list_q.is_queue) ? '0 : list_q.head;
        list_we    = 1'b1;
        list_wdata.count = list_q.count + CNT_W'(1);
        if (list_q.count == '0) begin
          list_wdata.head = free_head;
          list_wdata.tail = free_head;
        end else if (list_q.is_queue) begin
          list_wdata.tail = free_head;
        end else begin
          list_wdata.head = free_head;
        end
      end
      if (pop_ok) begin
        next_re = 1'b1;
        data_re = 1'b1;
      end
    end
    if (state == S_LINK) begin
      next_we    = 1'b1;
      next_waddr = list_q.tail;
      next_wdata = alloc_ptr;
    end
    if (state == S_POP) begin
      list_we          = 1'b1;
      list_wdata.head  = next_q;
      list_wdata.count = list_q.count - CNT_W'(1);
      next_we          = 1'b1;
      next_waddr       = list_q.head;
      next_wdata       = free_head;
    end
  end

  // List table
  always_ff @(posedge clk) begin
    if (list_we) list_mem[req_id] <= list_wdata;
    if (list_re) list_q <= list_mem[s_axis_tdata[5:2]];
  end

  // Pool link memory
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (next_re) next_q <= next_mem[next_raddr];
  end

  // Pool data memory
  always_ff @(posedge clk) begin
    if (data_we) data_mem[free_head] <= req_value;
    if (data_re) data_q <= data_mem[list_q.head];
  end

  // Sequence the request
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_LOOK;
      S_LOOK: begin
        if (pop_ok) state_next = S_POP;
        else if (need_link) state_next = S_LINK;
        else state_next = S_RESP;
      end
      S_LINK: state_next = S_RESP;
      S_POP:  state_next = S_RESP;
      S_RESP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      exists     <= '0;
      free_head  <= '0;
      free_count <= POOL_CNT;
      hwm        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOOK && create_ok) exists[req_id] <= 1'b1;
      if (state == S_LOOK && push_ok) begin
        free_head  <= free_next_ptr;
        free_count <= free_count - CNT_W'(1);
        if (virgin) hwm <= hwm_inc;
      end
      if (state == S_POP) begin
        free_head  <= list_q.head;
        free_count <= free_count + CNT_W'(1);
      end
      if (state == S_RESP && out_free) out_valid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd   <= cmd_t'(s_axis_tdata[1:0]);
      req_id    <= s_axis_tdata[5:2];
      req_kind  <= s_axis_tdata[6];
      req_value <= s_axis_tdata[38:7];
    end
    if (state == S_LOOK) begin
      alloc_ptr  <= free_head;
      res_status <= look_status;
      res_valid  <= 1'b0;
      res_value  <= '0;
    end
    if (state == S_POP) begin
      res_status <= ST_OK;
      res_valid  <= 1'b1;
      res_value  <= data_q;
    end
    if (state == S_RESP && out_free) begin
      out_status      <= res_status;
      out_value_valid <= res_valid;
      out_value       <= res_value;
    end
  end

  // Checks
  `MSQE_ASSERT_ALWAYS(a_free_bound, free_count <= POOL_CNT, "free count above pool size")
  `MSQE_ASSERT_ALWAYS(a_hwm_bound, hwm <= POOL_CNT, "high-water count above pool size")
  `MSQE_ASSERT_IMPLY(a_pop_nonempty, state == S_POP, list_q.count != '0, "pop on empty list")
  `MSQE_ASSERT_IMPLY(a_value_ok, m_axis_tvalid && out_value_valid, out_status == ST_OK, "bad status")
  `MSQE_ASSERT_NEXT(a_accept_look, accept, state == S_LOOK, "request not looked up")

endmodule

[tb/tb_multi_list_stack_queue_engine_core.sv]
// ----------------------------------------------------------------------------
// tb_multi_list_stack_queue_engine_core
// Drives create, push and pop requests into the list engine and checks each
// result against a behavioural model of the lists and the shared entry pool.
// A directed opener covers the status codes but full, LIFO and FIFO order and the
// ignored command. Random phases follow: a mixed phase, a pool fill past full
// and a drain, then a closing mixed phase. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_list_stack_queue_engine_core;
  import msqe_pkg::*;

  localparam int POOL  = 256;
  localparam int PTR_W = $clog2(POOL);

  typedef struct {
    status_t      status;
    logic         value_valid;
    logic [31:0]  value;
  } list_result_t;

  // Model of the lists and the free pool, plus the results still to arrive
  class list_pool_model;
    bit               present  [NUM_LISTS];
    bit               is_queue [NUM_LISTS];
    logic [PTR_W-1:0] head     [NUM_LISTS];
    logic [PTR_W-1:0] tail     [NUM_LISTS];
    int unsigned      depth    [NUM_LISTS];
    logic [31:0]      store    [POOL];
    logic [PTR_W-1:0] link     [POOL];
    logic [PTR_W-1:0] free_head;
    int unsigned      free_left;
    list_result_t     results_due[$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < NUM_LISTS; i++) begin
        present[i]  = 1'b0;
        is_queue[i] = 1'b0;
        head[i]     = '0;
        tail[i]     = '0;
        depth[i]    = 0;
      end
      // free chain runs i to i+1 and wraps at the end
      for (int i = 0; i < POOL; i++) begin
        store[i] = '0;
        link[i]  = PTR_W'((i + 1) % POOL);
      end
      free_head = '0;
      free_left = POOL;
      errors    = 0;
    endfunction

    // Apply one accepted request and queue the result it yields
    function void apply_command(cmd_t op, logic [3:0] id, logic kind, logic [31:0] word);
      list_result_t     r;
      logic [PTR_W-1:0] e;
      r.status      = ST_OK;
      r.value_valid = 1'b0;
      r.value       = '0;
      case (op)
        CMD_CREATE: begin
          if (present[id]) begin
            r.status = ST_EXISTS;
          end else begin
            present[id]  = 1'b1;
            is_queue[id] = kind;
            depth[id]    = 0;
          end
        end
        CMD_PUSH: begin
          if (!present[id]) begin
            r.status = ST_NOT_FOUND;
          end else if (free_left == 0) begin
            r.status = ST_FULL;
          end else begin
            e         = free_head;
            free_head = link[e];
            free_left--;
            store[e]  = word;
            if (depth[id] == 0) begin
              link[e]  = '0;
              head[id] = e;
              tail[id] = e;
            end else if (is_queue[id]) begin
              link[e]        = '0;
              link[tail[id]] = e;
              tail[id]       = e;
            end else begin
              link[e]  = head[id];
              head[id] = e;
            end
            depth[id]++;
          end
        end
        CMD_POP: begin
          if (!present[id]) begin
            r.status = ST_NOT_FOUND;
          end else if (depth[id] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            e             = head[id];
            r.value       = store[e];
            r.value_valid = 1'b1;
            head[id]      = link[e];
            depth[id]--;
            link[e]       = free_head;
            free_head     = e;
            free_left++;
          end
        end
        default: ;
      endcase
      results_due.insert(results_due.size(), r);
    endfunction

    // Compare one delivered result with the oldest one due
    function void compare_result(logic [OUT_TDATA_W-1:0] beat);
      list_result_t want;
      if (results_due.size() == 0) begin
        $display("%0t: result with none due: expected nothing, actual %h", $time, beat);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (beat[2:0] !== want.status) begin
        $display("%0t: status: expected %0d, actual %0d", $time, want.status, beat[2:0]);
        errors++;
      end
      if (beat[3] !== want.value_valid) begin
        $display("%0t: value_valid: expected %0d, actual %0d", $time, want.value_valid,
                 beat[3]);
        errors++;
      end
      if (beat[35:4] !== want.value) begin
        $display("%0t: popped_value: expected %h, actual %h", $time, want.value, beat[35:4]);
        errors++;
      end
    endfunction

    // Random existing list, optionally one holding entries; any id if none fits
    function logic [3:0] pick_list(bit need_entries);
      int hits[$];
      for (int i = 0; i < NUM_LISTS; i++) begin
        if (present[i] && (!need_entries || depth[i] != 0)) hits.insert(hits.size(), i);
      end
      if (hits.size() == 0) return 4'($urandom_range(0, NUM_LISTS - 1));
      return 4'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  list_pool_model board = new();
  int             send_calm = 0;
  int             recv_calm = 0;

  multi_list_stack_queue_engine_core #(
    .POOL_ENTRIES (POOL)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle cycles before the next request, with occasional stretches of none
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Offer one request, hold it until taken, then note it in the model
  task automatic send_request(cmd_t op, logic [3:0] id, logic kind, logic [31:0] word);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, word, kind, id, op};
    do @(posedge clk); while (!s_axis_tready);
    board.apply_command(op, id, kind, word);
  endtask

  // Hold the sender off until every result due has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
  endtask

  // Mixed traffic, mostly pushes and pops on lists that exist
  task automatic random_mix(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        send_request(CMD_CREATE, 4'($urandom), 1'($urandom), $urandom);
      else if (r < 8)
        send_request(CMD_NONE, 4'($urandom), 1'($urandom), $urandom);
      else if (r < 47)
        send_request(CMD_PUSH, board.pick_list(1'b0), 1'($urandom), $urandom);
      else if (r < 52)
        send_request(CMD_PUSH, 4'($urandom), 1'($urandom), $urandom);
      else if (r < 92)
        send_request(CMD_POP, board.pick_list(1'b1), 1'($urandom), $urandom);
      else
        send_request(CMD_POP, 4'($urandom), 1'($urandom), $urandom);
    end
  endtask

  // Receiver: random stall per result, then ready until one is taken
  initial begin
    int gap;
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Check every delivered result
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.compare_result(m_axis_tdata);
  end

  // Main sequence
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: status codes but full, stack and queue order, ignored command
    send_request(CMD_CREATE, 4'd0,  1'b0, 32'h0000_0000);
    send_request(CMD_CREATE, 4'd1,  1'b1, 32'hFFFF_FFFF);
    send_request(CMD_CREATE, 4'd0,  1'b1, 32'h0000_0000);
    send_request(CMD_PUSH,   4'd5,  1'b0, 32'hDEAD_BEEF);
    send_request(CMD_POP,    4'd5,  1'b1, 32'h0000_0000);
    send_request(CMD_POP,    4'd0,  1'b0, 32'h0000_0000);
    send_request(CMD_POP,    4'd1,  1'b0, 32'h0000_0000);
    send_request(CMD_PUSH,   4'd0,  1'b0, 32'h0000_0000);
    send_request(CMD_PUSH,   4'd0,  1'b1, 32'hFFFF_FFFF);
    send_request(CMD_PUSH,   4'd0,  1'b0, 32'hA5A5_5A5A);
    send_request(CMD_PUSH,   4'd1,  1'b0, 32'hFFFF_FFFF);
    send_request(CMD_PUSH,   4'd1,  1'b1, 32'h0000_0001);
    send_request(CMD_PUSH,   4'd1,  1'b0, 32'h8000_0000);
    send_request(CMD_POP,    4'd0,  1'b0, 32'h0000_0000);
    send_request(CMD_POP,    4'd0,  1'b0, 32'h0000_0000);
    send_request(CMD_PUSH,   4'd0,  1'b0, 32'h1234_5678);
    send_request(CMD_POP,    4'd0,  1'b0, 32'h0000_0000);
    send_request(CMD_POP,    4'd0,  1'b0, 32'h0000_0000);
    send_request(CMD_POP,    4'd0,  1'b0, 32'h0000_0000);
    send_request(CMD_POP,    4'd1,  1'b0, 32'h0000_0000);
    send_request(CMD_NONE,   4'd15, 1'b1, 32'hFFFF_FFFF);
    send_request(CMD_CREATE, 4'd15, 1'b1, 32'h0000_0000);
    send_request(CMD_PUSH,   4'd15, 1'b0, 32'h7FFF_FFFF);
    send_request(CMD_POP,    4'd1,  1'b0, 32'h0000_0000);
    send_request(CMD_POP,    4'd1,  1'b0, 32'h0000_0000);
    send_request(CMD_POP,    4'd1,  1'b0, 32'h0000_0000);

    random_mix(250);
    wait_drained();

    // fill the pool, then push past full
    while (board.free_left > 0)
      send_request(CMD_PUSH, board.pick_list(1'b0), 1'($urandom), $urandom);
    repeat (6) send_request(CMD_PUSH, board.pick_list(1'b0), 1'($urandom), $urandom);
    send_request(CMD_POP, board.pick_list(1'b1), 1'($urandom), $urandom);
    repeat (2) send_request(CMD_PUSH, board.pick_list(1'b0), 1'($urandom), $urandom);

    // drain most of the pool back
    repeat (240) begin
      if ($urandom_range(0, 99) < 88)
        send_request(CMD_POP, board.pick_list(1'b1), 1'($urandom), $urandom);
      else
        send_request(CMD_POP, 4'($urandom), 1'($urandom), $urandom);
    end
    wait_drained();

    random_mix(200);

    // wait out the last results
    wait_drained();
    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.results_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
